FILE: design/lexicase_selection_defines.svh
// assertion macros shared by the lexicase selection rtl
// every user has signals named clock and reset in scope
`ifndef LEXICASE_SELECTION_DEFINES_SVH
`define LEXICASE_SELECTION_DEFINES_SVH

// same-cycle implication, checked outside reset
`define LXS_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define LXS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/lxs_pkg.sv
`default_nettype none

package lxs_pkg;

   // sizing of the score table and scores
   localparam int MAX_ORGS   = 64;
   localparam int MAX_KEYS   = 8;
   localparam int VALUE_BITS = 32;

   localparam int ORG_BITS     = (MAX_ORGS > 1) ? $clog2(MAX_ORGS) : 1;
   localparam int KEY_BITS     = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
   localparam int ORG_CNT_BITS = $clog2(MAX_ORGS + 1);
   localparam int KEY_CNT_BITS = $clog2(MAX_KEYS + 1);
   localparam int ADDR_BITS    = $clog2(MAX_ORGS * MAX_KEYS);

   // channel field widths
   localparam int ORG_IDX_W = 6;
   localparam int KEY_IDX_W = 3;
   localparam int VALUE_W   = 32;
   localparam int SWAP_W    = 24;
   localparam int SWAP_FLD  = 3;
   localparam int POOL_W    = 64;
   localparam int TIE_W     = 6;
   localparam int TIE_CNT_W = $clog2(TIE_W);
   localparam int CHOSEN_W  = 6;
   localparam int SURV_W    = 7;
   localparam int USED_W    = 4;

   // operation codes
   localparam logic FUNC_LOAD   = 1'b0;
   localparam logic FUNC_SELECT = 1'b1;

   // register file
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;
   localparam int ORG_CNT_W   = 7;
   localparam int KEY_CNT_W   = 4;
   localparam int DIR_W       = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_ORG_COUNT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_COUNT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIRECTION = 2'd2;

   localparam logic [ORG_CNT_W-1:0] ORG_COUNT_RST = 7'd64;
   localparam logic [KEY_CNT_W-1:0] KEY_COUNT_RST = 4'd6;
   localparam logic [DIR_W-1:0]     DIRECTION_RST = 8'd9;

   // commands from the controller to the datapath
   typedef struct packed {
      logic req_open;
      logic swap_step;
      logic key_start;
      logic scan_run;
      logic key_end;
      logic mod_step;
      logic find_step;
      logic rsp_load;
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic sel_xfer;
      logic swap_last;
      logic scan_done;
      logic more_keys;
      logic mod_last;
      logic find_hit;
      logic out_free;
   } status_type;

   // swap target modulo active key count, by repeated subtraction
   function automatic logic [KEY_BITS-1:0] mod_small(input logic [SWAP_FLD-1:0] t,
                                                    input logic [KEY_CNT_BITS-1:0] n);
      logic [7:0] r;
      logic [7:0] d;
      r = 8'(t);
      d = 8'(n);
      for (int i = 0; i < (1 << SWAP_FLD) - 1; i++) begin
         if (r >= d) begin
            r = r - d;
         end
      end
      return r[KEY_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

FILE: design/lxs_req_if.sv
`default_nettype none

interface lxs_req_if;
   import lxs_pkg::*;

   logic                      valid;
   logic                      ready;
   logic                      func;
   logic [ORG_IDX_W-1:0]      org_index;
   logic [KEY_IDX_W-1:0]      key_index;
   logic signed [VALUE_W-1:0] value;
   logic [SWAP_W-1:0]         swap_targets;
   logic [POOL_W-1:0]         pool_mask;
   logic [TIE_W-1:0]          tie_pick;

   modport source (output valid, func, org_index, key_index, value, swap_targets,
                   pool_mask, tie_pick, input ready);
   modport sink (input valid, func, org_index, key_index, value, swap_targets,
                 pool_mask, tie_pick, output ready);
endinterface

`default_nettype wire

FILE: design/lxs_rsp_if.sv
`default_nettype none

interface lxs_rsp_if;
   import lxs_pkg::*;

   logic                valid;
   logic                ready;
   logic [CHOSEN_W-1:0] chosen_org;
   logic [SURV_W-1:0]   survivors;
   logic [USED_W-1:0]   keys_used;

   modport source (output valid, chosen_org, survivors, keys_used, input ready);
   modport sink (input valid, chosen_org, survivors, keys_used, output ready);
endinterface

`default_nettype wire

FILE: design/lxs_ram.sv
`default_nettype none

module lxs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 512
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end
endmodule

`default_nettype wire

FILE: design/lxs_datapath.sv
`default_nettype none

module lxs_datapath (
   input  wire logic                            clock,
   input  wire logic                            reset,
   lxs_req_if.sink                              req,
   lxs_rsp_if.source                            rsp,
   input  wire logic                            csr_we,
   input  wire logic [lxs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [lxs_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  wire lxs_pkg::cmd_type                cmd,
   output lxs_pkg::status_type                  status
);
   import lxs_pkg::*;

   `include "lexicase_selection_defines.svh"

   // configuration
   logic [ORG_CNT_W-1:0] org_count_ff, org_count_in;
   logic [KEY_CNT_W-1:0] key_count_ff, key_count_in;
   logic [DIR_W-1:0]     dir_ff, dir_in;

   // key order and swap pass
   logic [MAX_KEYS-1:0][KEY_BITS-1:0] key_order_ff, key_order_in;
   logic [SWAP_W-1:0]                 swap_tgt_ff, swap_tgt_in;
   logic [KEY_BITS-1:0]               swap_idx_ff, swap_idx_in;

   // filtering
   logic [MAX_ORGS-1:0]         pool_ff, pool_in;
   logic [MAX_ORGS-1:0]         next_ff, next_in;
   logic [ORG_CNT_BITS-1:0]     next_cnt_ff, next_cnt_in;
   logic [ORG_CNT_BITS-1:0]     surv_ff, surv_in;
   logic [KEY_CNT_BITS-1:0]     used_ff, used_in;
   logic [KEY_BITS-1:0]         cur_key_ff, cur_key_in;
   logic                        maxi_ff, maxi_in;
   logic [ORG_CNT_BITS-1:0]     issue_idx_ff, issue_idx_in;
   logic                        rd_vld_ff, rd_vld_in;
   logic [ORG_BITS-1:0]         rd_idx_ff, rd_idx_in;
   logic signed [VALUE_BITS-1:0] best_ff, best_in;
   logic                        have_ff, have_in;

   // tie break
   logic [TIE_W-1:0]        tie_ff, tie_in;
   logic [ORG_CNT_BITS-1:0] rem_ff, rem_in;
   logic [TIE_CNT_W-1:0]    mod_cnt_ff, mod_cnt_in;
   logic [ORG_BITS-1:0]     find_idx_ff, find_idx_in;

   // result register
   logic                rsp_vld_ff, rsp_vld_in;
   logic [CHOSEN_W-1:0] rsp_chosen_ff, rsp_chosen_in;
   logic [SURV_W-1:0]   rsp_surv_ff, rsp_surv_in;
   logic [USED_W-1:0]   rsp_used_ff, rsp_used_in;

   // combinational helpers
   logic [ORG_CNT_BITS-1:0]      n_orgs;
   logic [KEY_CNT_BITS-1:0]      n_keys;
   logic [MAX_ORGS-1:0]          in_use;
   logic [MAX_ORGS-1:0]          masked;
   logic                         req_xfer;
   logic                         ram_we;
   logic [ADDR_BITS-1:0]         ram_waddr;
   logic [VALUE_BITS-1:0]        ram_wdata;
   logic                         ram_re;
   logic [ADDR_BITS-1:0]         ram_raddr;
   logic [VALUE_BITS-1:0]        ram_rdata;
   logic signed [VALUE_BITS-1:0] score;
   logic                         better;
   logic [KEY_BITS-1:0]          swap_t;
   logic [KEY_CNT_BITS-1:0]      used_inc;
   logic [ORG_CNT_BITS-1:0]      rem_shift;
   logic                         find_hit;

   // clamp the active organism and key counts, a count of zero acting as one
   always_comb begin
      if (org_count_ff == '0) begin
         n_orgs = ORG_CNT_BITS'(1);
      end else if (int'(org_count_ff) > MAX_ORGS) begin
         n_orgs = ORG_CNT_BITS'(MAX_ORGS);
      end else begin
         n_orgs = ORG_CNT_BITS'(org_count_ff);
      end
      if (key_count_ff == '0) begin
         n_keys = KEY_CNT_BITS'(1);
      end else if (int'(key_count_ff) > MAX_KEYS) begin
         n_keys = KEY_CNT_BITS'(MAX_KEYS);
      end else begin
         n_keys = KEY_CNT_BITS'(key_count_ff);
      end
      for (int i = 0; i < MAX_ORGS; i++) begin
         in_use[i] = ORG_CNT_BITS'(i) < n_orgs;
      end
   end

   // score table
   assign req_xfer  = req.valid && cmd.req_open;
   assign ram_we    = req_xfer && (req.func == FUNC_LOAD)
                      && (int'(req.org_index) < MAX_ORGS)
                      && (int'(req.key_index) < MAX_KEYS);
   assign ram_waddr = ADDR_BITS'(int'(req.org_index) * MAX_KEYS + int'(req.key_index));
   assign ram_wdata = VALUE_BITS'(req.value);
   assign ram_re    = cmd.scan_run && (issue_idx_ff < n_orgs);
   assign ram_raddr = ADDR_BITS'(int'(issue_idx_ff) * MAX_KEYS + int'(cur_key_ff));

   lxs_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (MAX_ORGS * MAX_KEYS)
   ) u_score_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign masked    = req.pool_mask[MAX_ORGS-1:0] & in_use;
   assign score     = signed'(ram_rdata);
   assign better    = maxi_ff ? (score > best_ff) : (score < best_ff);
   assign swap_t    = mod_small(swap_tgt_ff[SWAP_FLD-1:0], n_keys);
   assign used_inc  = used_ff + KEY_CNT_BITS'(1);
   assign rem_shift = {rem_ff[ORG_CNT_BITS-2:0], tie_ff[TIE_W-1]};
   assign find_hit  = pool_ff[find_idx_ff] && (rem_ff == '0);

   // next-state logic of the datapath
   always_comb begin
      org_count_in  = org_count_ff;
      key_count_in  = key_count_ff;
      dir_in        = dir_ff;
      key_order_in  = key_order_ff;
      swap_tgt_in   = swap_tgt_ff;
      swap_idx_in   = swap_idx_ff;
      pool_in       = pool_ff;
      next_in       = next_ff;
      next_cnt_in   = next_cnt_ff;
      surv_in       = surv_ff;
      used_in       = used_ff;
      cur_key_in    = cur_key_ff;
      maxi_in       = maxi_ff;
      issue_idx_in  = issue_idx_ff;
      rd_vld_in     = 1'b0;
      rd_idx_in     = rd_idx_ff;
      best_in       = best_ff;
      have_in       = have_ff;
      tie_in        = tie_ff;
      rem_in        = rem_ff;
      mod_cnt_in    = mod_cnt_ff;
      find_idx_in   = find_idx_ff;
      rsp_vld_in    = rsp_vld_ff && !rsp.ready;
      rsp_chosen_in = rsp_chosen_ff;
      rsp_surv_in   = rsp_surv_ff;
      rsp_used_in   = rsp_used_ff;

      // register writes, a key count write restores the identity order
      if (csr_we) begin
         case (csr_index)
            CSR_ORG_COUNT: org_count_in = csr_wdata[ORG_CNT_W-1:0];
            CSR_KEY_COUNT: begin
               key_count_in = csr_wdata[KEY_CNT_W-1:0];
               for (int k = 0; k < MAX_KEYS; k++) begin
                  key_order_in[k] = KEY_BITS'(k);
               end
            end
            CSR_DIRECTION: dir_in = csr_wdata[DIR_W-1:0];
            default: ;
         endcase
      end

      // select transfer: capture the item and build the starting pool
      if (req_xfer && (req.func == FUNC_SELECT)) begin
         swap_tgt_in = req.swap_targets;
         swap_idx_in = '0;
         pool_in     = (masked != '0) ? masked : in_use;
         used_in     = '0;
         tie_in      = req.tie_pick;
         rem_in      = '0;
         mod_cnt_in  = '0;
         find_idx_in = '0;
      end

      // one swap of the key order per cycle
      if (cmd.swap_step) begin
         key_order_in[swap_idx_ff] = key_order_ff[swap_t];
         key_order_in[swap_t]      = key_order_ff[swap_idx_ff];
         swap_tgt_in = swap_tgt_ff >> SWAP_FLD;
         swap_idx_in = swap_idx_ff + KEY_BITS'(1);
      end

      // open a key: pick it from the order and clear the scan state
      if (cmd.key_start) begin
         cur_key_in   = key_order_ff[used_ff[KEY_BITS-1:0]];
         maxi_in      = dir_ff[key_order_ff[used_ff[KEY_BITS-1:0]]];
         issue_idx_in = '0;
         have_in      = 1'b0;
         next_in      = '0;
         next_cnt_in  = '0;
      end

      // issue one score read per cycle
      if (ram_re) begin
         issue_idx_in = issue_idx_ff + ORG_CNT_BITS'(1);
         rd_vld_in    = 1'b1;
         rd_idx_in    = issue_idx_ff[ORG_BITS-1:0];
      end

      // fold the returned score into best value and survivor set
      if (rd_vld_ff && pool_ff[rd_idx_ff]) begin
         if (!have_ff || better) begin
            best_in            = score;
            have_in            = 1'b1;
            next_in            = '0;
            next_in[rd_idx_ff] = 1'b1;
            next_cnt_in        = ORG_CNT_BITS'(1);
         end else if (score == best_ff) begin
            next_in[rd_idx_ff] = 1'b1;
            next_cnt_in        = next_cnt_ff + ORG_CNT_BITS'(1);
         end
      end

      // close a key
      if (cmd.key_end) begin
         pool_in = next_ff;
         surv_in = next_cnt_ff;
         used_in = used_inc;
      end

      // tie_pick modulo survivors, one restoring bit per cycle
      if (cmd.mod_step) begin
         rem_in     = (rem_shift >= surv_ff) ? (rem_shift - surv_ff) : rem_shift;
         tie_in     = tie_ff << 1;
         mod_cnt_in = mod_cnt_ff + TIE_CNT_W'(1);
      end

      // walk the survivors in ascending order to the picked one
      if (cmd.find_step && !find_hit) begin
         if (pool_ff[find_idx_ff]) begin
            rem_in = rem_ff - ORG_CNT_BITS'(1);
         end
         find_idx_in = find_idx_ff + ORG_BITS'(1);
      end

      // result register
      if (cmd.rsp_load) begin
         rsp_vld_in    = 1'b1;
         rsp_chosen_in = CHOSEN_W'(find_idx_ff);
         rsp_surv_in   = SURV_W'(surv_ff);
         rsp_used_in   = USED_W'(used_ff);
      end
   end

   // control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         org_count_ff <= ORG_COUNT_RST;
         key_count_ff <= KEY_COUNT_RST;
         dir_ff       <= DIRECTION_RST;
         for (int k = 0; k < MAX_KEYS; k++) begin
            key_order_ff[k] <= KEY_BITS'(k);
         end
         pool_ff      <= '0;
         swap_idx_ff  <= '0;
         used_ff      <= '0;
         issue_idx_ff <= '0;
         rd_vld_ff    <= 1'b0;
         have_ff      <= 1'b0;
         next_cnt_ff  <= '0;
         surv_ff      <= '0;
         mod_cnt_ff   <= '0;
         find_idx_ff  <= '0;
         rem_ff       <= '0;
         rsp_vld_ff   <= 1'b0;
      end else begin
         org_count_ff <= org_count_in;
         key_count_ff <= key_count_in;
         dir_ff       <= dir_in;
         key_order_ff <= key_order_in;
         pool_ff      <= pool_in;
         swap_idx_ff  <= swap_idx_in;
         used_ff      <= used_in;
         issue_idx_ff <= issue_idx_in;
         rd_vld_ff    <= rd_vld_in;
         have_ff      <= have_in;
         next_cnt_ff  <= next_cnt_in;
         surv_ff      <= surv_in;
         mod_cnt_ff   <= mod_cnt_in;
         find_idx_ff  <= find_idx_in;
         rem_ff       <= rem_in;
         rsp_vld_ff   <= rsp_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      swap_tgt_ff   <= swap_tgt_in;
      next_ff       <= next_in;
      cur_key_ff    <= cur_key_in;
      maxi_ff       <= maxi_in;
      rd_idx_ff     <= rd_idx_in;
      best_ff       <= best_in;
      tie_ff        <= tie_in;
      rsp_chosen_ff <= rsp_chosen_in;
      rsp_surv_ff   <= rsp_surv_in;
      rsp_used_ff   <= rsp_used_in;
   end

   // handshakes and status
   assign req.ready      = cmd.req_open;
   assign rsp.valid      = rsp_vld_ff;
   assign rsp.chosen_org = rsp_chosen_ff;
   assign rsp.survivors  = rsp_surv_ff;
   assign rsp.keys_used  = rsp_used_ff;

   assign status.sel_xfer  = req_xfer && (req.func == FUNC_SELECT);
   assign status.swap_last = (KEY_CNT_BITS'(swap_idx_ff) == (n_keys - KEY_CNT_BITS'(1)));
   assign status.scan_done = (issue_idx_ff == n_orgs) && !rd_vld_ff;
   assign status.more_keys = (next_cnt_ff > ORG_CNT_BITS'(1)) && (used_inc < n_keys);
   assign status.mod_last  = (mod_cnt_ff == TIE_CNT_W'(TIE_W - 1));
   assign status.find_hit  = find_hit;
   assign status.out_free  = !rsp_vld_ff || rsp.ready;

   `LXS_ASSERT_IMPL(a_rsp_no_overwrite, cmd.rsp_load, !rsp_vld_ff || rsp.ready, "result overwritten")
   `LXS_ASSERT_IMPL(a_key_keeps_one, cmd.key_end, next_cnt_ff != '0, "key filter left no candidate")
   `LXS_ASSERT_IMPL(a_find_in_range, cmd.find_step, ORG_CNT_BITS'(find_idx_ff) < n_orgs, "tie walk past active organisms")
endmodule

`default_nettype wire

FILE: design/lxs_ctrl.sv
`default_nettype none

module lxs_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire lxs_pkg::status_type status,
   output lxs_pkg::cmd_type         cmd
);
   import lxs_pkg::*;

   `include "lexicase_selection_defines.svh"

   typedef enum logic [7:0] {
      S_IDLE = 8'b0000_0001,
      S_SWAP = 8'b0000_0010,
      S_KEY  = 8'b0000_0100,
      S_SCAN = 8'b0000_1000,
      S_EVAL = 8'b0001_0000,
      S_MOD  = 8'b0010_0000,
      S_FIND = 8'b0100_0000,
      S_OUT  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (status.sel_xfer) state_in = S_SWAP;
         S_SWAP: if (status.swap_last) state_in = S_KEY;
         S_KEY:  state_in = S_SCAN;
         S_SCAN: if (status.scan_done) state_in = S_EVAL;
         S_EVAL: state_in = status.more_keys ? S_KEY : S_MOD;
         S_MOD:  if (status.mod_last) state_in = S_FIND;
         S_FIND: if (status.find_hit) state_in = S_OUT;
         S_OUT:  if (status.out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // commands
   assign cmd.req_open  = (state_ff == S_IDLE);
   assign cmd.swap_step = (state_ff == S_SWAP);
   assign cmd.key_start = (state_ff == S_KEY);
   assign cmd.scan_run  = (state_ff == S_SCAN);
   assign cmd.key_end   = (state_ff == S_EVAL);
   assign cmd.mod_step  = (state_ff == S_MOD);
   assign cmd.find_step = (state_ff == S_FIND);
   assign cmd.rsp_load  = (state_ff == S_OUT) && status.out_free;

   `LXS_ASSERT_NEXT(a_select_starts_swap, (state_ff == S_IDLE) && status.sel_xfer, cmd.swap_step, "select transfer did not start the swap pass")
   `LXS_ASSERT_NEXT(a_out_returns_idle, cmd.rsp_load, cmd.req_open, "no return to idle after result")
endmodule

`default_nettype wire

FILE: design/lexicase_selection.sv
`default_nettype none
// channel   dir  handshake      payload
// req_chan  in   valid/ready    func, org_index, key_index, value, swap_targets,
//                               pool_mask, tie_pick
// rsp_chan  out  valid/ready    chosen_org, survivors, keys_used
// csr_*     in   csr_we         csr_index, csr_wdata (write only)
//
// a load gives no result; a select runs a swap pass over the key order, then for each
// key applied one score read per organism plus pipeline, a restoring tie_pick modulo
// the survivors, a walk to the chosen survivor and a load of the result register
// a stalled rsp_chan holds the block only once a second select result is ready
// reset is synchronous; the score table is not cleared and must be loaded before use

module lexicase_selection (
   input  wire logic                            clock,
   input  wire logic                            reset,
   lxs_req_if.sink                              req_chan,
   lxs_rsp_if.source                            rsp_chan,
   input  wire logic                            csr_we,
   input  wire logic [lxs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [lxs_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import lxs_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencing
   lxs_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   // score table, key order, filtering and result register
   lxs_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .rsp       (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status)
   );
endmodule

`default_nettype wire

FILE: tb/lxs_selection_checker.sv
`default_nettype none

module lxs_selection_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   lxs_req_if                                   req_mon,
   lxs_rsp_if                                   rsp_mon,
   input  wire logic                            csr_we,
   input  wire logic [lxs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [lxs_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                                   fail_count,
   output int                                   pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import lxs_pkg::*;

   typedef struct packed {
      logic [CHOSEN_W-1:0] chosen_org;
      logic [SURV_W-1:0]   survivors;
      logic [USED_W-1:0]   keys_used;
   } parent_pick_type;

   // shadow of the block state and registers
   logic signed [VALUE_W-1:0] score_mem [MAX_ORGS][MAX_KEYS];
   logic [KEY_BITS-1:0]       key_seq [MAX_KEYS];
   logic [ORG_CNT_W-1:0]      org_count_q;
   logic [KEY_CNT_W-1:0]      key_count_q;
   logic [DIR_W-1:0]          dir_q;

   // picks of accepted selections, oldest first
   parent_pick_type pick_q [$];
   parent_pick_type want;
   int              errors  = 0;
   int              waiting = 0;

   assign fail_count = errors;
   assign pending    = waiting;

   function automatic int orgs_in_use();
      if (org_count_q < 1) return 1;
      if (org_count_q > MAX_ORGS) return MAX_ORGS;
      return int'(org_count_q);
   endfunction

   function automatic int keys_in_use();
      if (key_count_q < 1) return 1;
      if (key_count_q > MAX_KEYS) return MAX_KEYS;
      return int'(key_count_q);
   endfunction

   function automatic void order_reset();
      for (int k = 0; k < MAX_KEYS; k++) begin
         key_seq[k] = KEY_BITS'(k);
      end
   endfunction

   // permute the key order, then filter candidates key by key and break the tie
   function automatic parent_pick_type run_selection(input logic [SWAP_W-1:0] swaps,
                                                     input logic [POOL_W-1:0] mask,
                                                     input logic [TIE_W-1:0]  tie);
      int                        n_orgs;
      int                        n_keys;
      int                        t;
      int                        used;
      int                        surv;
      int                        pick;
      int                        sel;
      bit                        found;
      bit                        have;
      bit                        maxi;
      logic [KEY_BITS-1:0]       tmp;
      logic [KEY_BITS-1:0]       key;
      logic [POOL_W-1:0]         in_use;
      logic [POOL_W-1:0]         pool;
      logic [POOL_W-1:0]         kept;
      logic signed [VALUE_W-1:0] best;
      parent_pick_type           res;
      n_orgs = orgs_in_use();
      n_keys = keys_in_use();
      for (int i = 0; i < n_keys; i++) begin
         t = int'(swaps[SWAP_FLD*i +: SWAP_FLD]) % n_keys;
         tmp        = key_seq[i];
         key_seq[i] = key_seq[t];
         key_seq[t] = tmp;
      end

      // an empty pool after masking means every organism in use
      in_use = (n_orgs >= POOL_W) ? '1 : ((POOL_W'(1) << n_orgs) - POOL_W'(1));
      pool   = mask & in_use;
      if (pool == '0) pool = in_use;

      used = 0;
      do begin
         key  = key_seq[used];
         maxi = dir_q[key];
         have = 1'b0;
         best = '0;
         kept = '0;
         for (int i = 0; i < n_orgs; i++) begin
            if (pool[i] && (!have || (maxi ? score_mem[i][key] > best
                                           : score_mem[i][key] < best))) begin
               best = score_mem[i][key];
               have = 1'b1;
            end
         end
         for (int i = 0; i < n_orgs; i++) begin
            if (pool[i] && score_mem[i][key] == best) kept[i] = 1'b1;
         end
         pool = kept;
         used++;
      end while ($countones(pool) > 1 && used < n_keys);

      // tie break in ascending index order
      surv  = $countones(pool);
      pick  = int'(tie) % surv;
      sel   = 0;
      found = 1'b0;
      for (int i = 0; i < n_orgs; i++) begin
         if (pool[i] && !found) begin
            if (pick == 0) begin
               sel   = i;
               found = 1'b1;
            end else begin
               pick--;
            end
         end
      end
      res.chosen_org = CHOSEN_W'(sel);
      res.survivors  = SURV_W'(surv);
      res.keys_used  = USED_W'(used);
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         order_reset();
         org_count_q = ORG_COUNT_RST;
         key_count_q = KEY_COUNT_RST;
         dir_q       = DIRECTION_RST;
         pick_q.delete();
      end else begin
         // register writes
         if (csr_we) begin
            case (csr_index)
               CSR_ORG_COUNT: org_count_q = csr_wdata[ORG_CNT_W-1:0];
               CSR_KEY_COUNT: begin
                  key_count_q = csr_wdata[KEY_CNT_W-1:0];
                  order_reset();
               end
               CSR_DIRECTION: dir_q = csr_wdata[DIR_W-1:0];
               default: ;
            endcase
         end

         // input transfer: loads fill the table, selections queue a pick
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.func == FUNC_SELECT) begin
               pick_q.insert(pick_q.size(),
                             run_selection(req_mon.swap_targets, req_mon.pool_mask,
                                           req_mon.tie_pick));
            end else begin
               score_mem[req_mon.org_index][req_mon.key_index] = req_mon.value;
            end
         end

         // result transfer against the oldest pick
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pick_q.size() == 0) begin
               $error("result with no selection outstanding: chosen_org %0d",
                      rsp_mon.chosen_org);
               errors++;
            end else begin
               want = pick_q.pop_front();
               if (rsp_mon.chosen_org !== want.chosen_org) begin
                  $error("chosen_org mismatch: expected %0d, actual %0d",
                         want.chosen_org, rsp_mon.chosen_org);
                  errors++;
               end
               if (rsp_mon.survivors !== want.survivors) begin
                  $error("survivors mismatch: expected %0d, actual %0d",
                         want.survivors, rsp_mon.survivors);
                  errors++;
               end
               if (rsp_mon.keys_used !== want.keys_used) begin
                  $error("keys_used mismatch: expected %0d, actual %0d",
                         want.keys_used, rsp_mon.keys_used);
                  errors++;
               end
            end
         end
      end
      waiting = pick_q.size();
   end

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import lxs_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED = 2'd3;
   localparam int HOLD_CYCLES = 2500;
   localparam int TAIL_CYCLES = 700;
   localparam int REG_SETTLE  = 16;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   int                     fail_count;
   int                     pending;

   // which table entries hold a loaded score, and the counts in use
   bit loaded [MAX_ORGS][MAX_KEYS];
   int act_orgs = MAX_ORGS;
   int act_keys = 6;

   bit steady    = 1'b0;
   bit hold_ask  = 1'b0;
   bit hold_done = 1'b0;
   int n_items    = 0;
   int n_loads    = 0;
   int n_selects  = 0;
   int n_settings = 1;

   lxs_req_if req_chan ();
   lxs_rsp_if rsp_chan ();

   lexicase_selection dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   lxs_selection_checker chk (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_chan),
      .rsp_mon    (rsp_chan),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int clamp(input int v, input int lo, input int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // mostly a few small values so that ties are common, plus extremes and noise
   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(9))
         0, 1, 2, 3, 4, 5: return VALUE_W'(int'($urandom_range(3)) - 2);
         6: return {1'b0, {(VALUE_W-1){1'b1}}};
         7: return {1'b1, {(VALUE_W-1){1'b0}}};
         default: return VALUE_W'($urandom);
      endcase
   endfunction

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0]  data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
      if (idx == CSR_ORG_COUNT) act_orgs = clamp(int'(data[ORG_CNT_W-1:0]), 1, MAX_ORGS);
      if (idx == CSR_KEY_COUNT) act_keys = clamp(int'(data[KEY_CNT_W-1:0]), 1, MAX_KEYS);
   endtask

   // wait for every outstanding selection, then let the block go quiet
   task automatic settle(input int cycles);
      req_chan.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (cycles) @(negedge clock);
   endtask

   // one input transfer, with random gaps ahead of it unless steady is set
   task automatic push_req(input logic                      func,
                           input logic [ORG_IDX_W-1:0]      org,
                           input logic [KEY_IDX_W-1:0]      key,
                           input logic signed [VALUE_W-1:0] value,
                           input logic [SWAP_W-1:0]         swaps,
                           input logic [POOL_W-1:0]         mask,
                           input logic [TIE_W-1:0]          tie);
      while (!steady && $urandom_range(99) < 13) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.func         <= func;
      req_chan.org_index    <= org;
      req_chan.key_index    <= key;
      req_chan.value        <= value;
      req_chan.swap_targets <= swaps;
      req_chan.pool_mask    <= mask;
      req_chan.tie_pick     <= tie;
      do begin
         @(posedge clock);
      end while (!req_chan.ready);
      @(negedge clock);
      n_items++;
   endtask

   task automatic load_score(input int org, input int key,
                             input logic signed [VALUE_W-1:0] value);
      push_req(FUNC_LOAD, ORG_IDX_W'(org), KEY_IDX_W'(key), value, SWAP_W'($urandom),
               {$urandom, $urandom}, TIE_W'($urandom));
      loaded[org][key] = 1'b1;
      n_loads++;
   endtask

   // load any score the selection could read before issuing it
   task automatic select_parent(input logic [SWAP_W-1:0] swaps,
                                input logic [POOL_W-1:0] mask,
                                input logic [TIE_W-1:0]  tie);
      logic [POOL_W-1:0] in_use;
      logic [POOL_W-1:0] pool;
      in_use = (act_orgs >= POOL_W) ? '1 : ((POOL_W'(1) << act_orgs) - POOL_W'(1));
      pool   = mask & in_use;
      if (pool == '0) pool = in_use;
      for (int o = 0; o < act_orgs; o++) begin
         if (pool[o]) begin
            for (int k = 0; k < act_keys; k++) begin
               if (!loaded[o][k]) load_score(o, k, pick_value());
            end
         end
      end
      push_req(FUNC_SELECT, ORG_IDX_W'($urandom), KEY_IDX_W'($urandom), VALUE_W'($urandom),
               swaps, mask, tie);
      n_selects++;
   endtask

   // one register setting followed by a random mix of loads and selections
   task automatic run_phase(input logic [CSR_DATA_W-1:0] org_w,
                            input logic [CSR_DATA_W-1:0] key_w,
                            input logic [CSR_DATA_W-1:0] dir_w,
                            input int                    count,
                            input bit                    steady_en,
                            input bit                    stall_en);
      int                first;
      logic [POOL_W-1:0] mask;
      settle(REG_SETTLE);
      write_reg(CSR_ORG_COUNT, org_w);
      write_reg(CSR_KEY_COUNT, key_w);
      write_reg(CSR_DIRECTION, dir_w);
      write_reg(CSR_UNMAPPED, CSR_DATA_W'($urandom));
      n_settings++;
      steady <= steady_en;
      first = n_items;
      while (n_items - first < count) begin
         if (stall_en && n_items - first >= 8) hold_ask <= 1'b1;
         if ($urandom_range(99) < 40) begin
            load_score($urandom_range(MAX_ORGS-1), $urandom_range(MAX_KEYS-1), pick_value());
         end else begin
            case ($urandom_range(9))
               0: mask = '0;
               1: mask = POOL_W'(1) << $urandom_range(POOL_W-1);
               2: mask = '1;
               3, 4: mask = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
               default: mask = {$urandom, $urandom};
            endcase
            select_parent(SWAP_W'($urandom), mask, TIE_W'($urandom_range(63)));
         end
      end
   endtask

   // result side: random stalls, one long hold-off on request
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_ask && !hold_done) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_done = 1'b1;
         end else if (steady) begin
            rsp_chan.ready <= 1'b1;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= 13);
         end
      end
   end

   initial begin
      #60_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      reset                 = 1'b1;
      csr_we                = 1'b0;
      csr_index             = '0;
      csr_wdata             = '0;
      req_chan.valid        = 1'b0;
      req_chan.func         = FUNC_LOAD;
      req_chan.org_index    = '0;
      req_chan.key_index    = '0;
      req_chan.value        = '0;
      req_chan.swap_targets = '0;
      req_chan.pool_mask    = '0;
      req_chan.tie_pick     = '0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: four organisms, three keys, key 1 minimized
      write_reg(CSR_ORG_COUNT, 8'd4);
      write_reg(CSR_KEY_COUNT, 8'd3);
      write_reg(CSR_DIRECTION, 8'h05);
      load_score(0, 0, 32'sh7FFF_FFFF);
      load_score(1, 0, 32'sh7FFF_FFFF);
      load_score(2, 0, 32'sh8000_0000);
      load_score(3, 0, -32'sd1);
      load_score(0, 1, -32'sd1);
      load_score(1, 1, -32'sd1);
      load_score(2, 1, 32'sd0);
      load_score(3, 1, -32'sd1);
      load_score(0, 2, 32'sd0);
      load_score(1, 2, 32'sd0);
      load_score(2, 2, 32'sd7);
      load_score(3, 2, 32'sh8000_0000);
      load_score(MAX_ORGS-1, MAX_KEYS-1, 32'sh8000_0000);

      // empty mask, full mask, mask only beyond the organisms in use, lone candidate
      select_parent('0, '0, '0);
      select_parent('1, '1, '1);
      select_parent('0, 64'hFFFF_FFFF_FFFF_FFF0, 6'd1);
      select_parent(24'h00_00FA, 64'h4, 6'd5);
      select_parent(SWAP_W'($urandom), 64'hB, 6'd62);

      // random part across register settings, the extremes first
      run_phase(8'd1, 8'd1, 8'h00, 40, 1'b0, 1'b0);
      run_phase(8'd64, 8'd2, 8'hFF, 60, 1'b0, 1'b0);
      run_phase(8'd0, 8'd0, CSR_DATA_W'($urandom), 30, 1'b0, 1'b0);
      run_phase(8'hFF, 8'h02, CSR_DATA_W'($urandom), 30, 1'b0, 1'b0);
      run_phase(8'd5, 8'd9, CSR_DATA_W'($urandom), 30, 1'b0, 1'b0);
      for (int p = 0; p < 6; p++) begin
         run_phase(CSR_DATA_W'($urandom_range(2, 16)), CSR_DATA_W'($urandom_range(1, 8)),
                   CSR_DATA_W'($urandom), 35, p == 2, p == 4);
      end

      settle(TAIL_CYCLES);
      $display("covered %0d score loads and %0d selections over %0d register settings",
               n_loads, n_selects, n_settings);
      $display("result side held off for %0d cycles once, back-pressuring the input",
               HOLD_CYCLES);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
